### hdl/tlpm_pkg.sv
// shared sizes and types for the two-level page map with clock replacement
// no dependencies
package tlpm_pkg;

  localparam int unsigned Processes   = 3;
  localparam int unsigned DirEntries  = 16;
  localparam int unsigned PagesPerDir = 16;
  localparam int unsigned Frames      = 32;

  localparam int unsigned ProcW  = 2;
  localparam int unsigned DirW   = $clog2(DirEntries);
  localparam int unsigned PageW  = $clog2(PagesPerDir);
  localparam int unsigned FrameW = $clog2(Frames);
  localparam int unsigned DirIdxW   = $clog2(Processes * DirEntries);
  localparam int unsigned EntryIdxW = $clog2(Processes * DirEntries * PagesPerDir);

  typedef struct packed {
    logic              valid;
    logic              swapped;
    logic [FrameW-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic [ProcW-1:0] proc;
    logic [DirW-1:0]  dir;
    logic [PageW-1:0] page;
  } owner_t;

  typedef struct packed {
    logic [FrameW-1:0] frame_number;
    logic              dir_fault;
    logic              page_fault;
    logic              swap_in;
    logic              evicted;
    logic [1:0]        evicted_process;
    logic [3:0]        evicted_dir;
    logic [3:0]        evicted_page;
    logic              out_of_range;
  } result_t;

  typedef struct packed {
    logic [1:0]  process_id;
    logic [31:0] virtual_address;
  } access_t;

endpackage

### hdl/tlpm_if.sv
// valid/ready channel interfaces for access and result items
// depends on tlpm_pkg
interface tlpm_access_if;
  import tlpm_pkg::*;
  logic    valid;
  logic    ready;
  access_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlpm_result_if;
  import tlpm_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/two_level_page_map_clock_replace.sv
// two-level page map with second-chance clock frame replacement
// depends on tlpm_pkg and tlpm_if; page entries and frame owners in synchronous memories
//
//  channel  dir  payload
//  acc_i    in   process_id, virtual_address
//  res_o    out  frame_number, flags, evicted owner, out_of_range
//
// a hit passes S_OUT, S_READ and S_DECIDE; an out-of-range item has its result
// registered at accept; a free frame adds S_WRITE; a new directory adds S_CLEAR,
// which clears its 16 page entries; an eviction adds S_SCAN, clearing the referenced
// bit of each referenced frame the clock passes (up to 32), then S_OWNER, S_VICTIM,
// S_MARK and S_WRITE. one item at a time; the result register holds until taken, and
// the next item is accepted only then. directory and referenced bits reset at once.
module two_level_page_map_clock_replace
  import tlpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tlpm_access_if.sink          acc_i,
  tlpm_result_if.source        res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_READ, S_DECIDE, S_SCAN, S_OWNER, S_VICTIM, S_MARK, S_WRITE, S_OUT
  } state_e;

  state_e state_q;

  entry_t page_mem [Processes*DirEntries*PagesPerDir];
  owner_t owner_mem [Frames];

  logic [Processes*DirEntries-1:0] dir_present_q;
  logic [Frames-1:0]               ref_q;
  logic [FrameW:0]                 alloc_q;
  logic [FrameW-1:0]               hand_q;

  logic [ProcW-1:0]  proc_q;
  logic [DirW-1:0]   dir_q;
  logic [PageW-1:0]  page_q;
  logic [PageW-1:0]  clr_q;
  logic [FrameW-1:0] frame_q;
  result_t           res_q;
  logic              res_valid_q;

  logic              ent_we;
  logic [EntryIdxW-1:0] ent_waddr, ent_raddr;
  entry_t            ent_wdata, ent_rdata_q;
  owner_t            own_rdata_q;

  logic [9:0]  va_dir, va_page;
  logic        in_range;
  logic [DirIdxW-1:0] di;

  // victim write uses the read data of the victim owner's entry
  logic vic_we_q;
  logic [EntryIdxW-1:0] vic_addr_q;

  assign va_dir  = acc_i.data.virtual_address[31:22];
  assign va_page = acc_i.data.virtual_address[21:12];
  assign in_range = (32'(acc_i.data.process_id) < Processes) &&
                    (32'(va_dir) < DirEntries) && (32'(va_page) < PagesPerDir);
  assign di = DirIdxW'(32'(proc_q) * DirEntries + 32'(dir_q));

  function automatic logic [EntryIdxW-1:0] eidx(logic [ProcW-1:0] p, logic [DirW-1:0] d,
                                                 logic [PageW-1:0] g);
    return EntryIdxW'((32'(p) * DirEntries + 32'(d)) * PagesPerDir + 32'(g));
  endfunction

  assign acc_i.ready = (state_q == S_IDLE) && !res_valid_q;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  always_comb begin
    ent_raddr = eidx(proc_q, dir_q, page_q);
    ent_we    = 1'b0;
    ent_waddr = eidx(proc_q, dir_q, page_q);
    ent_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = eidx(proc_q, dir_q, clr_q);
      end
      S_VICTIM: begin
        ent_raddr = eidx(own_rdata_q.proc, own_rdata_q.dir, own_rdata_q.page);
      end
      S_MARK: begin
        ent_we    = vic_we_q;
        ent_waddr = vic_addr_q;
        ent_wdata = '{valid: ent_rdata_q.valid, swapped: 1'b1, frame: ent_rdata_q.frame};
      end
      S_WRITE: begin
        ent_we    = 1'b1;
        ent_wdata = '{valid: 1'b1, swapped: 1'b0, frame: frame_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) page_mem[ent_waddr] <= ent_wdata;
    ent_rdata_q <= page_mem[ent_raddr];
    own_rdata_q <= owner_mem[frame_q];
    if (state_q == S_WRITE) owner_mem[frame_q] <= '{proc: proc_q, dir: dir_q, page: page_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      dir_present_q <= '0;
      ref_q         <= '0;
      alloc_q       <= '0;
      hand_q        <= '0;
      res_valid_q   <= 1'b0;
      vic_we_q      <= 1'b0;
      vic_addr_q    <= '0;
      proc_q <= '0; dir_q <= '0; page_q <= '0; clr_q <= '0; frame_q <= '0;
      res_q  <= '0;
    end else begin
      if (res_o.valid && res_o.ready) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc_i.valid && acc_i.ready) begin
            res_q <= '{out_of_range: !in_range, default: '0};
            if (!in_range) begin
              res_valid_q <= 1'b1;
            end else begin
              proc_q <= acc_i.data.process_id;
              dir_q  <= DirW'(va_dir);
              page_q <= PageW'(va_page);
              clr_q  <= '0;
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // directory check
          if (!dir_present_q[di]) begin
            dir_present_q[di] <= 1'b1;
            res_q.dir_fault <= 1'b1;
            state_q <= S_CLEAR;
          end else begin
            state_q <= S_READ;
          end
        end
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == PagesPerDir - 1) state_q <= S_READ;
        end
        S_READ: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (ent_rdata_q.valid && !ent_rdata_q.swapped) begin
            res_q.frame_number <= ent_rdata_q.frame;
            ref_q[ent_rdata_q.frame] <= 1'b1;
            res_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            res_q.page_fault <= !ent_rdata_q.valid;
            res_q.swap_in    <= ent_rdata_q.valid;
            if (32'(alloc_q) < Frames) begin
              frame_q <= FrameW'(alloc_q);
              alloc_q <= alloc_q + 1'b1;
              state_q <= S_WRITE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ref_q[hand_q]) begin
            ref_q[hand_q] <= 1'b0;
            hand_q <= FrameW'((32'(hand_q) + 1) % Frames);
          end else begin
            frame_q <= hand_q;
            hand_q  <= FrameW'((32'(hand_q) + 1) % Frames);
            state_q <= S_OWNER;
          end
        end
        S_OWNER: state_q <= S_VICTIM;
        S_VICTIM: begin
          res_q.evicted         <= 1'b1;
          res_q.evicted_process <= own_rdata_q.proc;
          res_q.evicted_dir     <= 4'(own_rdata_q.dir);
          res_q.evicted_page    <= 4'(own_rdata_q.page);
          vic_addr_q <= eidx(own_rdata_q.proc, own_rdata_q.dir, own_rdata_q.page);
          vic_we_q   <= (32'(own_rdata_q.proc) < Processes);
          state_q <= S_MARK;
        end
        S_MARK: begin
          vic_we_q <= 1'b0;
          state_q  <= S_WRITE;
        end
        S_WRITE: begin
          res_q.frame_number <= frame_q;
          ref_q[frame_q] <= 1'b1;
          res_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### test/testbench.sv
// self-checking testbench for the two-level page map with clock replacement
// depends on tlpm_pkg, tlpm_if and two_level_page_map_clock_replace
module testbench;
  import tlpm_pkg::*;

  logic clk_i;
  logic rst_ni;

  tlpm_access_if acc_ch ();
  tlpm_result_if res_ch ();

  two_level_page_map_clock_replace u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc_ch.sink),
    .res_o  (res_ch.source)
  );

  // predictor state
  logic             dir_live [Processes*DirEntries];
  logic             pte_valid [Processes*DirEntries*PagesPerDir];
  logic             pte_swapped [Processes*DirEntries*PagesPerDir];
  logic [FrameW-1:0] pte_frame [Processes*DirEntries*PagesPerDir];
  owner_t           owner_of [Frames];
  logic             ref_bit [Frames];
  int unsigned      used_frames;
  int unsigned      hand;

  access_t pending_accesses[$];
  result_t expected_results[$];
  int      error_count;
  bit      stim_done;
  bit      quiet;
  bit      acc_fired;
  int      hold_cycles;
  int      long_hold;
  int      send_gap;
  int      recv_gap;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic result_t translate(access_t a);
    result_t r;
    int unsigned p, d, g, di, ei, fr, oi;
    r = '0;
    p = 32'(a.process_id);
    d = 32'(a.virtual_address[31:22]);
    g = 32'(a.virtual_address[21:12]);
    if (p >= Processes || d >= DirEntries || g >= PagesPerDir) begin
      r.out_of_range = 1'b1;
      return r;
    end
    di = p * DirEntries + d;
    if (!dir_live[di]) begin
      dir_live[di] = 1'b1;
      for (int k = 0; k < PagesPerDir; k++) begin
        pte_valid[di*PagesPerDir+k] = 1'b0;
        pte_swapped[di*PagesPerDir+k] = 1'b0;
        pte_frame[di*PagesPerDir+k] = '0;
      end
      r.dir_fault = 1'b1;
    end
    ei = di * PagesPerDir + g;
    if (!pte_valid[ei]) r.page_fault = 1'b1;
    else if (pte_swapped[ei]) r.swap_in = 1'b1;
    if (r.page_fault || r.swap_in) begin
      if (used_frames < Frames) begin
        fr = used_frames;
        used_frames++;
      end else begin
        fr = hand;
        for (int n = 0; n <= Frames; n++) begin
          if (!ref_bit[fr]) break;
          ref_bit[fr] = 1'b0;
          fr = (fr + 1) % Frames;
        end
        hand = (fr + 1) % Frames;
        r.evicted = 1'b1;
        r.evicted_process = owner_of[fr].proc;
        r.evicted_dir = owner_of[fr].dir;
        r.evicted_page = owner_of[fr].page;
        if (owner_of[fr].proc < Processes) begin
          oi = (owner_of[fr].proc * DirEntries + owner_of[fr].dir) * PagesPerDir
               + owner_of[fr].page;
          pte_swapped[oi] = 1'b1;
        end
      end
      pte_valid[ei] = 1'b1;
      pte_swapped[ei] = 1'b0;
      pte_frame[ei] = FrameW'(fr);
      owner_of[fr].proc = ProcW'(p);
      owner_of[fr].dir = DirW'(d);
      owner_of[fr].page = PageW'(g);
    end else begin
      fr = 32'(pte_frame[ei]);
    end
    ref_bit[fr] = 1'b1;
    r.frame_number = FrameW'(fr);
    return r;
  endfunction

  function automatic access_t make_access(int p, int d, int g);
    access_t a;
    a.process_id = 2'(p);
    a.virtual_address = {d[9:0], g[9:0], 12'($urandom)};
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_ch.valid <= 1'b0;
      acc_ch.data <= '0;
      send_gap <= 0;
    end else if (acc_ch.valid && !acc_fired) begin
    end else if (send_gap > 0) begin
      acc_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_accesses.size() > 0) begin
      acc_ch.valid <= 1'b1;
      acc_ch.data <= pending_accesses.pop_front();
      if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 9);
    end else begin
      acc_ch.valid <= 1'b0;
    end
  end

  // receiver readiness
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      recv_gap <= 0;
      long_hold <= 0;
    end else if (hold_cycles > 0 && long_hold < hold_cycles) begin
      res_ch.ready <= 1'b0;
      long_hold <= long_hold + 1;
    end else if (recv_gap > 0) begin
      res_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 9);
    end
  end

  // monitor: predict on accept, compare on result
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    acc_fired <= rst_ni && acc_ch.valid && acc_ch.ready;
    if (rst_ni) begin
      if (acc_ch.valid && acc_ch.ready) expected_results.push_back(translate(acc_ch.data));
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (expected_results.size() == 0) begin
          report("unexpected item", 32'(got), 32'(0));
        end else begin
          want = expected_results.pop_front();
          if (got.frame_number !== want.frame_number)
            report("frame_number", 32'(got.frame_number), 32'(want.frame_number));
          if (got.dir_fault !== want.dir_fault)
            report("dir_fault", 32'(got.dir_fault), 32'(want.dir_fault));
          if (got.page_fault !== want.page_fault)
            report("page_fault", 32'(got.page_fault), 32'(want.page_fault));
          if (got.swap_in !== want.swap_in)
            report("swap_in", 32'(got.swap_in), 32'(want.swap_in));
          if (got.evicted !== want.evicted)
            report("evicted", 32'(got.evicted), 32'(want.evicted));
          if (got.evicted_process !== want.evicted_process)
            report("evicted_process", 32'(got.evicted_process), 32'(want.evicted_process));
          if (got.evicted_dir !== want.evicted_dir)
            report("evicted_dir", 32'(got.evicted_dir), 32'(want.evicted_dir));
          if (got.evicted_page !== want.evicted_page)
            report("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
          if (got.out_of_range !== want.out_of_range)
            report("out_of_range", 32'(got.out_of_range), 32'(want.out_of_range));
        end
      end
    end
  end

  initial begin
    access_t a;
    int hot_proc, hot_dir;
    for (int i = 0; i < Processes*DirEntries; i++) dir_live[i] = 1'b0;
    for (int i = 0; i < Frames; i++) begin
      ref_bit[i] = 1'b0;
      owner_of[i] = '0;
    end
    used_frames = 0;
    hand = 0;
    error_count = 0;
    stim_done = 1'b0;
    quiet = 1'b0;
    hold_cycles = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: range edges, hits, swap-outs, bad process id
    pending_accesses.push_back(make_access(0, 0, 0));
    pending_accesses.push_back(make_access(0, 0, 0));
    pending_accesses.push_back(make_access(2, 15, 15));
    pending_accesses.push_back(make_access(3, 0, 0));
    pending_accesses.push_back(make_access(0, 16, 0));
    pending_accesses.push_back(make_access(0, 0, 16));
    a.process_id = 2'd1;
    a.virtual_address = 32'hFFFF_FFFF;
    pending_accesses.push_back(a);
    a.virtual_address = 32'h03FF_FFFF;
    pending_accesses.push_back(a);
    for (int i = 0; i < 34; i++) pending_accesses.push_back(make_access(1, 3, i % 16 + 0));
    for (int i = 0; i < 36; i++) pending_accesses.push_back(make_access(i % 3, i / 3, i % 16));
    pending_accesses.push_back(make_access(0, 0, 0));

    // random: mostly valid accesses, some in a working set, some out of range
    for (int i = 0; i < 680; i++) begin
      if (i == 200) hold_cycles = 400;
      if (i % 40 == 0) begin
        hot_proc = $urandom_range(0, Processes - 1);
        hot_dir = $urandom_range(0, DirEntries - 1);
      end
      if (i >= 600) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          a.process_id = 2'($urandom);
          a.virtual_address = $urandom;
          pending_accesses.push_back(a);
        end
        1, 2, 3: pending_accesses.push_back(make_access(hot_proc, hot_dir,
                                                        $urandom_range(0, 15)));
        default: pending_accesses.push_back(make_access($urandom_range(0, Processes - 1),
                                                        $urandom_range(0, 15),
                                                        $urandom_range(0, 15)));
      endcase
      while (pending_accesses.size() > 8) @(posedge clk_i);
    end

    while (pending_accesses.size() > 0 || acc_ch.valid) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

### files.f
hdl/tlpm_pkg.sv
hdl/tlpm_if.sv
hdl/two_level_page_map_clock_replace.sv
test/testbench.sv
